// ===== hw/rtl/pm_pkg.sv =====
// shared constants, codes and controller/datapath interface types for the pattern metronome
package pm_pkg;

	localparam int MAX_LEN   = 64;
	localparam int NBANKS    = 3;
	localparam int DEPTH     = NBANKS * MAX_LEN;
	localparam int LEN_W     = $clog2(MAX_LEN + 1);
	localparam int IDX_W     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int BANK_W    = $clog2(NBANKS);
	localparam int ADDR_W    = $clog2(DEPTH);
	localparam int OP_W      = 3;
	localparam int VALUE_W   = 16;
	localparam int KIND_W    = 2;
	localparam int STEPNOW_W = 6;
	localparam int STEP_W    = 16;
	localparam int DIVD_W    = STEP_W + 1;
	localparam int CNT_W     = $clog2(DIVD_W + 1);

	localparam logic [OP_W-1:0] OP_TICK  = 3'd0;
	localparam logic [OP_W-1:0] OP_START = 3'd1;
	localparam logic [OP_W-1:0] OP_STOP  = 3'd2;
	localparam logic [OP_W-1:0] OP_ENTRY = 3'd3;
	localparam logic [OP_W-1:0] OP_SETSTEP = 3'd4;

	localparam logic [KIND_W-1:0] KIND_BEAT   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ACCEPT = 2'd1;
	localparam logic [KIND_W-1:0] KIND_REJECT = 2'd2;
	localparam logic [KIND_W-1:0] KIND_EMPTY  = 2'd3;

	typedef struct packed {
		logic latch;
		logic dec_count;
		logic clear_run;
		logic set_step;
		logic entry;
		logic start_arm;
		logic set_empty;
		logic fire;
		logic mod_commit;
		logic rd;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            last;
		logic            running;
		logic            cd_gt1;
		logic            len_zero;
		logic            mod_done;
		logic            out_free;
	} sts_t;

endpackage

// ===== hw/rtl/pm_mod.sv =====
// iterative remainder unit for the step advance, one dividend bit per cycle
module pm_mod (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [pm_pkg::DIVD_W-1:0]   dividend,
	input  logic [pm_pkg::LEN_W-1:0]    divisor,
	output logic                        done,
	output logic [pm_pkg::LEN_W-1:0]    rem
);

	logic                         busy_q;
	logic                         done_q;
	logic [pm_pkg::CNT_W-1:0]     cnt_q;
	logic [pm_pkg::LEN_W-1:0]     r_q;
	logic [pm_pkg::LEN_W-1:0]     div_q;
	logic [pm_pkg::DIVD_W-1:0]    sh_q;
	logic [pm_pkg::LEN_W:0]       trial;
	logic                         fast;

	assign fast  = dividend <= pm_pkg::DIVD_W'(divisor);
	assign trial = {r_q, sh_q[pm_pkg::DIVD_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				if (fast) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= pm_pkg::CNT_W'(pm_pkg::DIVD_W);
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - pm_pkg::CNT_W'(1);
				if (cnt_q == pm_pkg::CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= divisor;
			sh_q  <= dividend;
			if (fast) begin
				r_q <= (dividend == pm_pkg::DIVD_W'(divisor)) ? '0
					: dividend[pm_pkg::LEN_W-1:0];
			end else begin
				r_q <= '0;
			end
		end else if (busy_q) begin
			sh_q <= {sh_q[pm_pkg::DIVD_W-2:0], 1'b0};
			if (trial >= {1'b0, div_q}) begin
				r_q <= pm_pkg::LEN_W'(trial - {1'b0, div_q});
			end else begin
				r_q <= trial[pm_pkg::LEN_W-1:0];
			end
		end
	end

	assign done = done_q;
	assign rem  = r_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("remainder unit started while busy");

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (r_q < div_q))
		else $error("remainder not below divisor");

endmodule

// ===== hw/rtl/pm_dpath.sv =====
// datapath: pattern banks, step and countdown registers, output register
module pm_dpath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pm_pkg::cmd_t                  cmd,
	output pm_pkg::sts_t                  sts,
	input  logic [pm_pkg::OP_W-1:0]       operation,
	input  logic [pm_pkg::VALUE_W-1:0]    value,
	input  logic                          last,
	input  logic                          cfg_write,
	input  logic                          cfg_data,
	input  logic                          out_stall,
	output logic                          out_valid,
	output logic [pm_pkg::KIND_W-1:0]     kind,
	output logic [pm_pkg::STEPNOW_W-1:0]  step_now,
	output logic                          cycle_end
);

	logic [pm_pkg::OP_W-1:0]      op_q;
	logic [pm_pkg::VALUE_W-1:0]   value_q;
	logic                         last_q;

	logic [pm_pkg::VALUE_W-1:0]   bank_mem_q [pm_pkg::DEPTH];
	logic [pm_pkg::VALUE_W-1:0]   rd_data_q;
	logic [pm_pkg::LEN_W-1:0]     bank_len_q [pm_pkg::NBANKS];
	logic [pm_pkg::BANK_W-1:0]    active_q;
	logic [pm_pkg::BANK_W-1:0]    pending_q;
	logic [pm_pkg::BANK_W-1:0]    loading_q;
	logic                         pflag_q;
	logic [pm_pkg::LEN_W-1:0]     load_cnt_q;
	logic                         load_bad_q;
	logic [pm_pkg::STEP_W-1:0]    step_q;
	logic [pm_pkg::VALUE_W-1:0]   cd_q;
	logic                         running_q;
	logic                         sync_q;

	logic [pm_pkg::KIND_W-1:0]    res_kind_q;
	logic                         res_wrap_q;
	logic                         out_valid_q;
	logic [pm_pkg::KIND_W-1:0]    kind_q;
	logic [pm_pkg::STEPNOW_W-1:0] step_now_q;
	logic                         cycle_end_q;

	logic [pm_pkg::LEN_W-1:0]     len_act;
	logic [pm_pkg::LEN_W-1:0]     fire_len;
	logic                         fire_sw;
	logic                         ent_room;
	logic [pm_pkg::LEN_W-1:0]     ent_cnt;
	logic                         ent_bad;
	logic                         ent_ok;
	logic                         ent_direct;
	logic [pm_pkg::BANK_W-1:0]    new_active;
	logic [pm_pkg::BANK_W-1:0]    new_pend;
	logic [pm_pkg::BANK_W-1:0]    ent_free;
	logic                         out_free;
	logic                         mod_done;
	logic [pm_pkg::LEN_W-1:0]     mod_rem;
	logic [pm_pkg::ADDR_W-1:0]    wr_addr;
	logic [pm_pkg::ADDR_W-1:0]    rd_addr;

	function automatic logic [pm_pkg::ADDR_W-1:0] bank_addr(
		input logic [pm_pkg::BANK_W-1:0] bank,
		input logic [pm_pkg::IDX_W-1:0]  idx
	);
		bank_addr = pm_pkg::ADDR_W'(bank) * pm_pkg::ADDR_W'(pm_pkg::MAX_LEN)
			+ pm_pkg::ADDR_W'(idx);
	endfunction

	function automatic logic [pm_pkg::BANK_W-1:0] pick_free(
		input logic [pm_pkg::BANK_W-1:0] act,
		input logic                      pf,
		input logic [pm_pkg::BANK_W-1:0] pend
	);
		logic [pm_pkg::BANK_W-1:0] r;
		r = '0;
		for (int b = pm_pkg::NBANKS - 1; b >= 0; b--) begin
			if (pm_pkg::BANK_W'(b) != act && !(pf && pm_pkg::BANK_W'(b) == pend)) begin
				r = pm_pkg::BANK_W'(b);
			end
		end
		pick_free = r;
	endfunction

	assign len_act  = bank_len_q[active_q];
	assign fire_sw  = sync_q && pflag_q
		&& (step_q == pm_pkg::STEP_W'(len_act) - pm_pkg::STEP_W'(1));
	assign fire_len = fire_sw ? bank_len_q[pending_q] : len_act;

	assign ent_room   = load_cnt_q < pm_pkg::LEN_W'(pm_pkg::MAX_LEN);
	assign ent_cnt    = ent_room ? load_cnt_q + pm_pkg::LEN_W'(1) : load_cnt_q;
	assign ent_bad    = load_bad_q || !ent_room || (value_q == '0);
	assign ent_ok     = !ent_bad && (ent_cnt != '0);
	assign ent_direct = !sync_q || (len_act == '0);
	assign new_active = ent_direct ? loading_q : active_q;
	assign new_pend   = ent_direct ? pending_q : loading_q;
	assign ent_free   = pick_free(new_active, !ent_direct, new_pend);

	assign wr_addr  = bank_addr(loading_q, load_cnt_q[pm_pkg::IDX_W-1:0]);
	assign rd_addr  = bank_addr(active_q, step_q[pm_pkg::IDX_W-1:0]);
	assign out_free = !out_valid_q || !out_stall;

	pm_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.fire),
		.dividend ({1'b0, step_q} + pm_pkg::DIVD_W'(1)),
		.divisor  (fire_len),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	// latched beat and pattern memory
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q    <= operation;
			value_q <= value;
			last_q  <= last;
		end
		if (cmd.entry && ent_room) begin
			bank_mem_q[wr_addr] <= value_q;
		end
		if (cmd.rd) begin
			rd_data_q <= bank_mem_q[rd_addr];
		end
	end

	// result and output payload
	always_ff @(posedge clk) begin
		if (cmd.entry) begin
			res_kind_q <= ent_ok ? pm_pkg::KIND_ACCEPT : pm_pkg::KIND_REJECT;
			res_wrap_q <= 1'b0;
		end
		if (cmd.start_arm) begin
			res_kind_q <= pm_pkg::KIND_BEAT;
			res_wrap_q <= 1'b0;
		end
		if (cmd.set_empty) begin
			res_kind_q <= pm_pkg::KIND_EMPTY;
			res_wrap_q <= 1'b0;
		end
		if (cmd.mod_commit) begin
			res_kind_q <= pm_pkg::KIND_BEAT;
			res_wrap_q <= (mod_rem == '0);
		end
		if (cmd.emit) begin
			kind_q      <= res_kind_q;
			step_now_q  <= (res_kind_q == pm_pkg::KIND_BEAT)
				? step_q[pm_pkg::STEPNOW_W-1:0] : '0;
			cycle_end_q <= res_wrap_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < pm_pkg::NBANKS; i++) begin
				bank_len_q[i] <= '0;
			end
			active_q    <= pm_pkg::BANK_W'(0);
			pending_q   <= pm_pkg::BANK_W'(0);
			loading_q   <= pm_pkg::BANK_W'(1);
			pflag_q     <= 1'b0;
			load_cnt_q  <= '0;
			load_bad_q  <= 1'b0;
			step_q      <= '0;
			cd_q        <= '0;
			running_q   <= 1'b0;
			sync_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				sync_q <= cfg_data;
			end
			if (cmd.dec_count) begin
				cd_q <= cd_q - pm_pkg::VALUE_W'(1);
			end
			if (cmd.clear_run || cmd.set_empty) begin
				running_q <= 1'b0;
			end
			if (cmd.set_step) begin
				step_q <= value_q;
			end
			if (cmd.start_arm) begin
				running_q <= 1'b1;
				if (step_q >= pm_pkg::STEP_W'(len_act)) begin
					step_q <= '0;
				end
			end
			if (cmd.fire && fire_sw) begin
				pflag_q  <= 1'b0;
				active_q <= pending_q;
			end
			if (cmd.mod_commit) begin
				step_q <= pm_pkg::STEP_W'(mod_rem);
			end
			if (cmd.entry) begin
				if (!last_q) begin
					load_cnt_q <= ent_cnt;
					load_bad_q <= ent_bad;
				end else begin
					load_cnt_q <= '0;
					load_bad_q <= 1'b0;
					if (ent_ok) begin
						bank_len_q[loading_q] <= ent_cnt;
						active_q  <= new_active;
						pending_q <= new_pend;
						pflag_q   <= !ent_direct;
						loading_q <= ent_free;
					end
				end
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
				if (res_kind_q == pm_pkg::KIND_BEAT) begin
					cd_q <= rd_data_q;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.op       = op_q;
	assign sts.last     = last_q;
	assign sts.running  = running_q;
	assign sts.cd_gt1   = cd_q > pm_pkg::VALUE_W'(1);
	assign sts.len_zero = (len_act == '0);
	assign sts.mod_done = mod_done;
	assign sts.out_free = out_free;

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign step_now  = step_now_q;
	assign cycle_end = cycle_end_q;

	a_bank_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		active_q != loading_q)
		else $error("loading bank overlaps active bank");

	a_pend_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		pflag_q |-> (pending_q != loading_q && pending_q != active_q))
		else $error("pending bank overlaps another bank");

	a_beat_running: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && res_kind_q == pm_pkg::KIND_BEAT) |=> running_q)
		else $error("beat emitted while stopped");

endmodule

// ===== hw/rtl/pm_ctrl.sv =====
// controller state machine sequencing one beat through the datapath
module pm_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  pm_pkg::sts_t  sts,
	output pm_pkg::cmd_t  cmd
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_EXEC = 5'b00010,
		ST_MODW = 5'b00100,
		ST_RD   = 5'b01000,
		ST_EMIT = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = ST_IDLE;
				case (sts.op)
					pm_pkg::OP_TICK: begin
						if (sts.running) begin
							if (sts.cd_gt1) begin
								cmd.dec_count = 1'b1;
							end else if (sts.len_zero) begin
								cmd.clear_run = 1'b1;
							end else begin
								cmd.fire = 1'b1;
								state_d  = ST_MODW;
							end
						end
					end
					pm_pkg::OP_START: begin
						if (sts.len_zero) begin
							cmd.set_empty = 1'b1;
							state_d       = ST_EMIT;
						end else begin
							cmd.start_arm = 1'b1;
							state_d       = ST_RD;
						end
					end
					pm_pkg::OP_STOP: begin
						cmd.clear_run = 1'b1;
					end
					pm_pkg::OP_ENTRY: begin
						cmd.entry = 1'b1;
						if (sts.last) begin
							state_d = ST_EMIT;
						end
					end
					pm_pkg::OP_SETSTEP: begin
						cmd.set_step = 1'b1;
					end
					default: begin
						state_d = ST_IDLE;
					end
				endcase
			end
			ST_MODW: begin
				if (sts.mod_done) begin
					cmd.mod_commit = 1'b1;
					state_d        = ST_RD;
				end
			end
			ST_RD: begin
				cmd.rd  = 1'b1;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != ST_IDLE);

endmodule

// ===== hw/rtl/pattern_metronome.sv =====
// top level of the pattern metronome: controller, datapath and their ports
// The block takes one beat at a time; after a beat is taken the input stalls for the
// remainder of its work. A tick that does not expire the countdown, a stop, a set step,
// an unused operation code and a non-final pattern entry end in the execute state; a
// final pattern entry then passes the emit state; a start the read and emit states, or
// only the emit state when no pattern is loaded; a tick that emits a timed beat the
// remainder wait, read and emit states. The remainder is found at once when the new step
// index follows directly from the current one (index plus one within the length), and
// bit by bit when the step index was set beyond the length or a pattern switch shortens
// it: the remainder unit resolves one dividend bit per cycle. A result waits in the output
// register while the next beat is taken; a block that must emit again before that result
// leaves holds until it does. The pattern store is a single-port array with a registered read.
module pattern_metronome (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic                          cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [pm_pkg::OP_W-1:0]       operation,
	input  logic [pm_pkg::VALUE_W-1:0]    value,
	input  logic                          last,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [pm_pkg::KIND_W-1:0]     kind,
	output logic [pm_pkg::STEPNOW_W-1:0]  step_now,
	output logic                          cycle_end
);

	pm_pkg::cmd_t cmd;
	pm_pkg::sts_t sts;

	pm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	pm_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.operation (operation),
		.value     (value),
		.last      (last),
		.cfg_write (cfg_write),
		.cfg_data  (cfg_data),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.kind      (kind),
		.step_now  (step_now),
		.cycle_end (cycle_end)
	);

endmodule

// ===== test/pattern_metronome_tb.sv =====
// testbench for the pattern metronome: directed table, then random phases checked beat by beat
`timescale 1ns / 1ps

module pattern_metronome_tb;
	import pm_pkg::*;

	localparam int QUIET_LIMIT = 3000;
	localparam int SETTLE_CYCLES = 30;
	localparam int DRILL_ROWS = 27;

	typedef struct packed {
		logic [KIND_W-1:0]    kind;
		logic [STEPNOW_W-1:0] step_now;
		logic                 cycle_end;
	} note_t;

	typedef struct packed {
		logic                 setup;
		logic [OP_W-1:0]      op;
		logic [VALUE_W-1:0]   val;
		logic                 lst;
		logic                 typed;
		logic                 has;
		logic [KIND_W-1:0]    kind;
		logic [STEPNOW_W-1:0] step;
		logic                 ce;
	} drill_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic cfg_data = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [OP_W-1:0] operation = '0;
	logic [VALUE_W-1:0] value = '0;
	logic last = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [KIND_W-1:0] kind;
	logic [STEPNOW_W-1:0] step_now;
	logic cycle_end;

	// own copy of the metronome state
	logic [15:0] delays_mem [DEPTH] = '{default: '0};
	logic [6:0]  pat_len [NBANKS] = '{default: '0};
	logic [1:0]  live_bank = 2'd0;
	logic [1:0]  queued_bank = 2'd0;
	logic [1:0]  fill_bank = 2'd1;
	logic        queued_flag = 1'b0;
	logic [6:0]  fill_count = '0;
	logic        fill_bad = 1'b0;
	logic [15:0] step_pos = '0;
	logic [15:0] ticks_left = '0;
	logic        playing = 1'b0;
	logic        sync_cfg = 1'b0;

	note_t due_notes [$];
	note_t got, want;
	drill_t drill_rows [DRILL_ROWS];
	int fault_count = 0;
	int quiet_cycles = 0;
	bit steady = 1'b0;

	pattern_metronome dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.value(value),
		.last(last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.step_now(step_now),
		.cycle_end(cycle_end)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic bit predict_note(input logic [OP_W-1:0] op, input logic [15:0] val,
			input logic lst, output note_t res);
		int unsigned len;
		int unsigned nxt;
		res = '0;
		case (op)
			OP_TICK: begin
				if (!playing)
					return 1'b0;
				if (ticks_left > 16'd1) begin
					ticks_left = ticks_left - 16'd1;
					return 1'b0;
				end
				len = pat_len[live_bank];
				if (len == 0) begin
					playing = 1'b0;
					return 1'b0;
				end
				// pattern switch once the last step has been served
				if (step_pos == len - 1 && sync_cfg && queued_flag) begin
					queued_flag = 1'b0;
					live_bank = queued_bank;
					len = pat_len[live_bank];
				end
				nxt = (32'(step_pos) + 1) % len;
				step_pos = nxt[15:0];
				ticks_left = delays_mem[live_bank * MAX_LEN + step_pos];
				res.kind = KIND_BEAT;
				res.step_now = step_pos[5:0];
				res.cycle_end = (step_pos == 16'd0);
				return 1'b1;
			end
			OP_START: begin
				len = pat_len[live_bank];
				if (len == 0) begin
					playing = 1'b0;
					res.kind = KIND_EMPTY;
					return 1'b1;
				end
				if (step_pos >= len)
					step_pos = '0;
				ticks_left = delays_mem[live_bank * MAX_LEN + step_pos];
				playing = 1'b1;
				res.kind = KIND_BEAT;
				res.step_now = step_pos[5:0];
				return 1'b1;
			end
			OP_STOP: begin
				playing = 1'b0;
				return 1'b0;
			end
			OP_ENTRY: begin
				if (fill_count < MAX_LEN) begin
					delays_mem[fill_bank * MAX_LEN + fill_count] = val;
					fill_count = fill_count + 7'd1;
					if (val == 16'd0)
						fill_bad = 1'b1;
				end else begin
					fill_bad = 1'b1;
				end
				if (!lst)
					return 1'b0;
				if (fill_bad || fill_count == 0) begin
					fill_count = '0;
					fill_bad = 1'b0;
					res.kind = KIND_REJECT;
					return 1'b1;
				end
				pat_len[fill_bank] = fill_count;
				if (!sync_cfg || pat_len[live_bank] == 0) begin
					live_bank = fill_bank;
					queued_flag = 1'b0;
				end else begin
					queued_bank = fill_bank;
					queued_flag = 1'b1;
				end
				// lowest bank neither playing nor queued
				for (int b = NBANKS - 1; b >= 0; b--)
					if (b != live_bank && !(queued_flag && b == queued_bank))
						fill_bank = b[1:0];
				fill_count = '0;
				fill_bad = 1'b0;
				res.kind = KIND_ACCEPT;
				return 1'b1;
			end
			OP_SETSTEP: begin
				step_pos = val;
				return 1'b0;
			end
			default: return 1'b0;
		endcase
	endfunction

	task automatic deliver(input logic [OP_W-1:0] op, input logic [15:0] val, input logic lst,
			input bit pinned = 1'b0, input bit pin_has = 1'b0, input note_t pin_note = '0);
		note_t res;
		bit has;
		while (!steady && $urandom_range(99) < 27) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		value <= val;
		last <= lst;
		// beat held until taken
		do @(posedge clk); while (in_stall !== 1'b0);
		has = predict_note(op, val, lst, res);
		if (pinned) begin
			has = pin_has;
			res = pin_note;
		end
		if (has)
			due_notes.push_back(res);
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (due_notes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_sync(input logic mode);
		drain();
		cfg_write <= 1'b1;
		cfg_data <= mode;
		@(posedge clk);
		cfg_write <= 1'b0;
		sync_cfg = mode;
	endtask

	task automatic play_phase(input int quota);
		int sent;
		int pick;
		int n;
		int zpos;
		logic [15:0] v;
		sent = 0;
		while (sent < quota) begin
			pick = $urandom_range(99);
			if (pick < 45 || pick >= 92) begin
				deliver(OP_TICK, 16'($urandom_range(65535)), 1'($urandom_range(1)));
				sent++;
			end else if (pick < 55) begin
				deliver(OP_START, 16'($urandom_range(65535)), 1'($urandom_range(1)));
				sent++;
			end else if (pick < 58) begin
				deliver(OP_STOP, 16'($urandom_range(65535)), 1'($urandom_range(1)));
				sent++;
			end else if (pick < 64) begin
				v = ($urandom_range(3) == 0) ? 16'($urandom_range(65535)) :
					16'($urandom_range(70));
				deliver(OP_SETSTEP, v, 1'($urandom_range(1)));
				sent++;
			end else if (pick < 67) begin
				// unused codes, not counted
				deliver(OP_W'($urandom_range(7, 5)), 16'($urandom_range(65535)),
					1'($urandom_range(1)));
			end else begin
				pick = $urandom_range(99);
				if (pick < 70) begin
					n = $urandom_range(6, 1);
					for (int i = 0; i < n; i++)
						deliver(OP_ENTRY, 16'($urandom_range(($urandom_range(9) == 0) ? 12 : 3, 1)),
							i == n - 1);
				end else if (pick < 78) begin
					n = MAX_LEN;
					for (int i = 0; i < n; i++)
						deliver(OP_ENTRY, 16'($urandom_range(2, 1)), i == n - 1);
				end else if (pick < 86) begin
					n = $urandom_range(MAX_LEN + 6, MAX_LEN + 1);
					for (int i = 0; i < n; i++)
						deliver(OP_ENTRY, 16'($urandom_range(65535, 1)), i == n - 1);
				end else if (pick < 96) begin
					n = $urandom_range(5, 1);
					zpos = $urandom_range(n - 1);
					for (int i = 0; i < n; i++)
						deliver(OP_ENTRY, (i == zpos) ? 16'd0 : 16'($urandom_range(65535, 1)),
							i == n - 1);
				end else begin
					// list cut short, runs on into the next one
					n = $urandom_range(3, 1);
					for (int i = 0; i < n; i++)
						deliver(OP_ENTRY, 16'($urandom_range(3, 1)), 1'b0);
				end
				sent += n;
			end
		end
	endtask

	always @(posedge clk)
		out_stall <= !steady && ($urandom_range(99) < 27);

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			got.kind = kind;
			got.step_now = step_now;
			got.cycle_end = cycle_end;
			if (due_notes.size() == 0) begin
				fault_count++;
				if (fault_count <= 10)
					$display("unexpected result: kind %0d step_now %0d cycle_end %0d",
						got.kind, got.step_now, got.cycle_end);
			end else begin
				want = due_notes.pop_front();
				if (got.kind !== want.kind || got.step_now !== want.step_now ||
						got.cycle_end !== want.cycle_end) begin
					fault_count++;
					if (fault_count <= 10)
						$display("mismatch: expected kind %0d step_now %0d cycle_end %0d, got %0d %0d %0d",
							want.kind, want.step_now, want.cycle_end,
							got.kind, got.step_now, got.cycle_end);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == QUIET_LIMIT) begin
				$display("pattern_metronome test failed");
				$finish;
			end
		end
	end

	initial begin
		// setup, op, value, last, typed, has result, kind, step_now, cycle_end
		// setup rows carry the sync mode in value bit 0
		drill_rows = '{
			'{1'b1, OP_TICK,    16'd1,     1'b0, 1'b0, 1'b0, KIND_BEAT,   6'd0, 1'b0},
			'{1'b0, OP_START,   16'd0,     1'b0, 1'b1, 1'b1, KIND_EMPTY,  6'd0, 1'b0},
			'{1'b0, OP_TICK,    16'd0,     1'b0, 1'b1, 1'b0, KIND_BEAT,   6'd0, 1'b0},
			'{1'b0, OP_ENTRY,   16'd0,     1'b1, 1'b1, 1'b1, KIND_REJECT, 6'd0, 1'b0},
			'{1'b0, OP_ENTRY,   16'hffff,  1'b0, 1'b1, 1'b0, KIND_BEAT,   6'd0, 1'b0},
			'{1'b0, OP_ENTRY,   16'd0,     1'b1, 1'b1, 1'b1, KIND_REJECT, 6'd0, 1'b0},
			'{1'b0, OP_ENTRY,   16'd1,     1'b0, 1'b1, 1'b0, KIND_BEAT,   6'd0, 1'b0},
			'{1'b0, OP_ENTRY,   16'd2,     1'b1, 1'b1, 1'b1, KIND_ACCEPT, 6'd0, 1'b0},
			'{1'b0, OP_START,   16'd0,     1'b0, 1'b1, 1'b1, KIND_BEAT,   6'd0, 1'b0},
			'{1'b0, OP_ENTRY,   16'd1,     1'b1, 1'b1, 1'b1, KIND_ACCEPT, 6'd0, 1'b0},
			'{1'b0, OP_TICK,    16'd0,     1'b0, 1'b0, 1'b0, KIND_BEAT,   6'd0, 1'b0},
			'{1'b0, OP_TICK,    16'd0,     1'b0, 1'b0, 1'b0, KIND_BEAT,   6'd0, 1'b0},
			'{1'b0, OP_TICK,    16'd0,     1'b0, 1'b0, 1'b0, KIND_BEAT,   6'd0, 1'b0},
			'{1'b0, OP_SETSTEP, 16'hffff,  1'b0, 1'b1, 1'b0, KIND_BEAT,   6'd0, 1'b0},
			'{1'b0, OP_TICK,    16'd0,     1'b0, 1'b0, 1'b0, KIND_BEAT,   6'd0, 1'b0},
			'{1'b1, OP_TICK,    16'd0,     1'b0, 1'b0, 1'b0, KIND_BEAT,   6'd0, 1'b0},
			'{1'b0, OP_ENTRY,   16'd3,     1'b0, 1'b1, 1'b0, KIND_BEAT,   6'd0, 1'b0},
			'{1'b0, OP_ENTRY,   16'd1,     1'b1, 1'b1, 1'b1, KIND_ACCEPT, 6'd0, 1'b0},
			'{1'b0, OP_TICK,    16'd0,     1'b0, 1'b0, 1'b0, KIND_BEAT,   6'd0, 1'b0},
			'{1'b0, OP_START,   16'd0,     1'b0, 1'b0, 1'b0, KIND_BEAT,   6'd0, 1'b0},
			'{1'b0, OP_STOP,    16'd0,     1'b0, 1'b1, 1'b0, KIND_BEAT,   6'd0, 1'b0},
			'{1'b0, OP_TICK,    16'd0,     1'b0, 1'b1, 1'b0, KIND_BEAT,   6'd0, 1'b0},
			'{1'b0, 3'd5,       16'hffff,  1'b1, 1'b1, 1'b0, KIND_BEAT,   6'd0, 1'b0},
			'{1'b0, 3'd6,       16'd0,     1'b0, 1'b1, 1'b0, KIND_BEAT,   6'd0, 1'b0},
			'{1'b0, 3'd7,       16'h5a5a,  1'b1, 1'b1, 1'b0, KIND_BEAT,   6'd0, 1'b0},
			'{1'b0, OP_SETSTEP, 16'd9,     1'b0, 1'b1, 1'b0, KIND_BEAT,   6'd0, 1'b0},
			'{1'b0, OP_START,   16'd0,     1'b0, 1'b0, 1'b0, KIND_BEAT,   6'd0, 1'b0}
		};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		foreach (drill_rows[i]) begin
			if (drill_rows[i].setup)
				set_sync(drill_rows[i].val[0]);
			else
				deliver(drill_rows[i].op, drill_rows[i].val, drill_rows[i].lst,
					drill_rows[i].typed, drill_rows[i].has,
					'{drill_rows[i].kind, drill_rows[i].step, drill_rows[i].ce});
		end
		for (int p = 0; p < 6; p++) begin
			set_sync(p % 2 == 0);
			// one phase runs flat out on both sides
			steady = (p == 2);
			play_phase(305);
		end
		steady = 1'b0;
		drain();
		if (fault_count == 0)
			$display("pattern_metronome test passed");
		else
			$display("pattern_metronome test failed");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/pm_pkg.sv
hw/rtl/pm_mod.sv
hw/rtl/pm_dpath.sv
hw/rtl/pm_ctrl.sv
hw/rtl/pattern_metronome.sv
test/pattern_metronome_tb.sv
